FILE: rtl/triangle_plane_clipper_unit_defines.svh
// Assertion helpers shared by the checker.
`ifndef TRIANGLE_PLANE_CLIPPER_UNIT_DEFINES_SVH
`define TRIANGLE_PLANE_CLIPPER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle clipper check failed");

// Next-cycle implication, disabled in reset.
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle clipper check failed");

`endif

FILE: rtl/tpc_pkg.sv
`default_nettype none
package tpc_pkg;

  // How many result triangles an input triangle yields
  typedef enum logic [1:0] {
    CLIP_NONE,
    CLIP_ONE,
    CLIP_TWO,
    CLIP_ALL
  } clip_mode_t;

  // Configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } cfg_reg_t;

  // Normal z resets to 1.0 in Q16.16
  localparam int NORMAL_Z_RESET = 65536;

  // Vertex select within a triangle
  typedef logic [1:0] vidx_t;

endpackage
`default_nettype wire

FILE: rtl/tpc_dist_lane.sv
`default_nettype none
// Signed distance of one vertex to the plane: N . (V - P), three stages.
module tpc_dist_lane #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0][W-1:0]   v,
  input  logic [2:0][W-1:0]   p,
  input  logic [2:0][W-1:0]   n,
  output logic [2*W+1:0]      dot,
  output logic [2:0][W-1:0]   vo
);

  localparam int DFW = W + 1;
  localparam int PW  = 2 * W + 1;
  localparam int DW  = 2 * W + 2;

  logic signed [DFW-1:0] dif  [3];
  logic signed [PW-1:0]  prod [3];
  logic [2:0][W-1:0]     v1;
  logic [2:0][W-1:0]     v2;

  // stage 1: offset, stage 2: products, stage 3: dot-product sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dif[c]  <= DFW'($signed(v[c])) - DFW'($signed(p[c]));
        prod[c] <= PW'($signed(n[c])) * PW'(dif[c]);
      end
      v1   <= v;
      v2   <= v1;
      dot  <= DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);
      vo   <= v2;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tpc_isect_lane.sv
`default_nettype none
// One edge/plane intersection: restoring divide for t (one bit per stage),
// then A + round(|B-A| * t) with the sign of B-A.
module tpc_isect_lane #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*W+1:0]      num,
  input  logic [2*W+1:0]      den,
  input  logic [2:0][W-1:0]   a,
  input  logic [2:0][W:0]     dif,
  output logic [2:0][W-1:0]   a_out,
  output logic [2:0][W-1:0]   res
);

  localparam int DW = 2 * W + 2;
  localparam int PW = 2 * W + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

  logic [DW-1:0]       rem [W];
  logic [DW-1:0]       dv  [W];
  logic [W-1:0]        quo [W];
  logic [2:0][W-1:0]   ac  [W];
  logic [2:0][W-1:0]   mg  [W];
  logic [2:0]          ng  [W];

  logic [PW-1:0]       prd [3];
  logic [2:0][W-1:0]   am;
  logic [2:0]          nm;

  // divider pipeline, one quotient bit per stage
  genvar j;
  for (j = 0; j < W; j++) begin : g_div
    logic [DW-1:0]     r_in;
    logic [DW-1:0]     d_in;
    logic [W-1:0]      q_in;
    logic [2:0][W-1:0] a_in;
    logic [2:0][W-1:0] m_in;
    logic [2:0]        n_in;
    logic [DW:0]       sh;
    logic [DW:0]       sub;
    logic              ge;

    if (j == 0) begin : g_first
      // magnitude and sign of the edge vector
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          n_in[c] = dif[c][W];
          m_in[c] = dif[c][W] ? W'(-dif[c]) : dif[c][W-1:0];
        end
      end
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign a_in = a;
    end else begin : g_rest
      assign r_in = rem[j-1];
      assign d_in = dv[j-1];
      assign q_in = quo[j-1];
      assign a_in = ac[j-1];
      assign m_in = mg[j-1];
      assign n_in = ng[j-1];
    end

    assign sh  = {r_in, 1'b0};
    assign sub = sh - {1'b0, d_in};
    assign ge  = (sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? sub[DW-1:0] : sh[DW-1:0];
        quo[j] <= {q_in[W-2:0], ge};
        dv[j]  <= d_in;
        ac[j]  <= a_in;
        mg[j]  <= m_in;
        ng[j]  <= n_in;
      end
    end
  end

  // scale edge by t with rounding bias, then step from A
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prd[c] <= PW'(mg[W-1][c]) * PW'(quo[W-1]) + HALF;
        res[c] <= nm[c] ? am[c] - prd[c][2*W-1:W] : am[c] + prd[c][2*W-1:W];
      end
      am    <= ac[W-1];
      nm    <= ng[W-1];
      a_out <= am;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/triangle_plane_clipper_unit.sv
`default_nettype none
// Clips one triangle of three signed fixed-point vertices against the plane
// held in six configuration registers (point P, normal N; N need not be unit
// length). A vertex with N.(V-P) >= 0 is inside. Yields no triangle, the input
// triangle, one clipped triangle, or two (last_of_run marks the final one).
// Each input beat passes three distance stages, one select stage, a
// COORD_WIDTH-stage restoring divider for t and two interpolation stages
// before the output register. A new triangle is taken every cycle while the
// output is not stalled and the triangle yields at most one result. One
// yielding two holds the next back, as the single result port sends one per beat.
// Output back-pressure stalls the whole pipeline once its last stage is full.
module triangle_plane_clipper_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COORD_WIDTH-1:0]          in_v0_x,
  input  logic [COORD_WIDTH-1:0]          in_v0_y,
  input  logic [COORD_WIDTH-1:0]          in_v0_z,
  input  logic [COORD_WIDTH-1:0]          in_v1_x,
  input  logic [COORD_WIDTH-1:0]          in_v1_y,
  input  logic [COORD_WIDTH-1:0]          in_v1_z,
  input  logic [COORD_WIDTH-1:0]          in_v2_x,
  input  logic [COORD_WIDTH-1:0]          in_v2_y,
  input  logic [COORD_WIDTH-1:0]          in_v2_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COORD_WIDTH-1:0]          out_v0_x,
  output logic [COORD_WIDTH-1:0]          out_v0_y,
  output logic [COORD_WIDTH-1:0]          out_v0_z,
  output logic [COORD_WIDTH-1:0]          out_v1_x,
  output logic [COORD_WIDTH-1:0]          out_v1_y,
  output logic [COORD_WIDTH-1:0]          out_v1_z,
  output logic [COORD_WIDTH-1:0]          out_v2_x,
  output logic [COORD_WIDTH-1:0]          out_v2_y,
  output logic [COORD_WIDTH-1:0]          out_v2_z,
  output logic                            last_of_run
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = 2 * W + 2;
  localparam int NS  = W + 6;   // pipeline stages before the output register
  localparam int DLY = W + 2;   // stages inside the intersection lanes

  // configuration registers
  logic [2:0][W-1:0] pnt;
  logic [2:0][W-1:0] nrm;

  always_ff @(posedge clk) begin
    if (rst) begin
      pnt    <= '0;
      nrm[0] <= '0;
      nrm[1] <= '0;
      nrm[2] <= W'(tpc_pkg::NORMAL_Z_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tpc_pkg::REG_POINT_X:  pnt[0] <= cfg_data;
        tpc_pkg::REG_POINT_Y:  pnt[1] <= cfg_data;
        tpc_pkg::REG_POINT_Z:  pnt[2] <= cfg_data;
        tpc_pkg::REG_NORMAL_X: nrm[0] <= cfg_data;
        tpc_pkg::REG_NORMAL_Y: nrm[1] <= cfg_data;
        tpc_pkg::REG_NORMAL_Z: nrm[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: one enable, last stage may refill when empty
  logic [NS-1:0] vld;
  logic          rdy_out;
  logic          en;
  logic          ovld;
  logic          oidx;

  assign rdy_out  = !ovld || (out_ready && last_of_run);
  assign en       = rdy_out || !vld[NS-1];
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // distance lanes, one per vertex
  logic [2:0][W-1:0] vin [3];
  logic [2:0][W-1:0] vtx [3];
  logic [DW-1:0]     dst [3];

  assign vin[0] = {in_v0_z, in_v0_y, in_v0_x};
  assign vin[1] = {in_v1_z, in_v1_y, in_v1_x};
  assign vin[2] = {in_v2_z, in_v2_y, in_v2_x};

  genvar k;
  for (k = 0; k < 3; k++) begin : g_dist
    tpc_dist_lane #(.W(W)) u_dist (
      .clk  (clk),
      .en   (en),
      .v    (vin[k]),
      .p    (pnt),
      .n    (nrm),
      .dot  (dst[k]),
      .vo   (vtx[k])
    );
  end

  // inside test and edge selection
  logic [2:0]          ins;
  tpc_pkg::clip_mode_t mode_sel;
  tpc_pkg::vidx_t      ia, ja, ib, jb;

  always_comb begin
    for (int c = 0; c < 3; c++) ins[c] = ~dst[c][DW-1];
    mode_sel = tpc_pkg::CLIP_ONE;
    ia = 2'd0; ja = 2'd1; ib = 2'd1; jb = 2'd2;
    case (ins)
      3'b000: begin mode_sel = tpc_pkg::CLIP_NONE; end
      3'b001: begin ia = 2'd0; ja = 2'd1; ib = 2'd0; jb = 2'd2; end
      3'b010: begin ia = 2'd1; ja = 2'd0; ib = 2'd1; jb = 2'd2; end
      3'b100: begin ia = 2'd2; ja = 2'd0; ib = 2'd2; jb = 2'd1; end
      3'b011: begin
        mode_sel = tpc_pkg::CLIP_TWO;
        ia = 2'd0; ja = 2'd2; ib = 2'd1; jb = 2'd2;
      end
      3'b101: begin
        mode_sel = tpc_pkg::CLIP_TWO;
        ia = 2'd0; ja = 2'd1; ib = 2'd2; jb = 2'd1;
      end
      3'b110: begin
        mode_sel = tpc_pkg::CLIP_TWO;
        ia = 2'd1; ja = 2'd0; ib = 2'd2; jb = 2'd0;
      end
      default: begin mode_sel = tpc_pkg::CLIP_ALL; end
    endcase
  end

  // select stage registers
  tpc_pkg::clip_mode_t mode4;
  logic [2:0][W-1:0]   s2_4;
  logic [DW-1:0]       l0_num, l0_den, l1_num, l1_den;
  logic [2:0][W-1:0]   l0_a, l1_a;
  logic [2:0][W:0]     l0_dif, l1_dif;

  always_ff @(posedge clk) begin
    if (en) begin
      mode4  <= mode_sel;
      s2_4   <= vtx[2];
      l0_num <= dst[ia];
      l0_den <= dst[ia] - dst[ja];
      l1_num <= dst[ib];
      l1_den <= dst[ib] - dst[jb];
      l0_a   <= vtx[ia];
      l1_a   <= vtx[ib];
      for (int c = 0; c < 3; c++) begin
        l0_dif[c] <= (W+1)'($signed(vtx[ja][c])) - (W+1)'($signed(vtx[ia][c]));
        l1_dif[c] <= (W+1)'($signed(vtx[jb][c])) - (W+1)'($signed(vtx[ib][c]));
      end
    end
  end

  // intersection lanes
  logic [2:0][W-1:0] s0, s1, i0, i1;

  tpc_isect_lane #(.W(W)) u_isect0 (
    .clk   (clk),
    .en    (en),
    .num   (l0_num),
    .den   (l0_den),
    .a     (l0_a),
    .dif   (l0_dif),
    .a_out (s0),
    .res   (i0)
  );

  tpc_isect_lane #(.W(W)) u_isect1 (
    .clk   (clk),
    .en    (en),
    .num   (l1_num),
    .den   (l1_den),
    .a     (l1_a),
    .dif   (l1_dif),
    .a_out (s1),
    .res   (i1)
  );

  // mode and third vertex ride alongside the lanes
  tpc_pkg::clip_mode_t md  [DLY];
  logic [2:0][W-1:0]   s2d [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      md[0]  <= mode4;
      s2d[0] <= s2_4;
      for (int i = 1; i < DLY; i++) begin
        md[i]  <= md[i-1];
        s2d[i] <= s2d[i-1];
      end
    end
  end

  // output register: holds one input's results, sends one beat per cycle while out_ready is high
  tpc_pkg::clip_mode_t omode;
  logic [2:0][W-1:0]   os0, os1, os2, oi0, oi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
      oidx <= 1'b0;
    end else if (rdy_out) begin
      ovld <= vld[NS-1] && (md[DLY-1] != tpc_pkg::CLIP_NONE);
      oidx <= 1'b0;
    end else if (out_ready) begin
      oidx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      omode <= md[DLY-1];
      os0   <= s0;
      os1   <= s1;
      os2   <= s2d[DLY-1];
      oi0   <= i0;
      oi1   <= i1;
    end
  end

  // result triangle select
  logic [2:0][W-1:0] t0, t1, t2;

  always_comb begin
    t0 = os0; t1 = os1; t2 = os2;
    last_of_run = 1'b1;
    case (omode)
      tpc_pkg::CLIP_ONE: begin
        t1 = oi0; t2 = oi1;
      end
      tpc_pkg::CLIP_TWO: begin
        if (!oidx) begin
          t2 = oi0;
          last_of_run = 1'b0;
        end else begin
          t0 = os1; t1 = oi0; t2 = oi1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ovld;
  assign out_v0_x  = t0[0];
  assign out_v0_y  = t0[1];
  assign out_v0_z  = t0[2];
  assign out_v1_x  = t1[0];
  assign out_v1_y  = t1[1];
  assign out_v1_z  = t1[2];
  assign out_v2_x  = t2[0];
  assign out_v2_y  = t2[1];
  assign out_v2_z  = t2[2];

endmodule
`default_nettype wire

FILE: rtl/tpc_checker.sv
`default_nettype none
`include "triangle_plane_clipper_unit_defines.svh"
// Port-level checks on the result channel.
module tpc_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_v0_x,
  input logic [COORD_WIDTH-1:0] out_v0_y,
  input logic [COORD_WIDTH-1:0] out_v0_z,
  input logic [COORD_WIDTH-1:0] out_v1_x,
  input logic [COORD_WIDTH-1:0] out_v1_y,
  input logic [COORD_WIDTH-1:0] out_v1_z,
  input logic [COORD_WIDTH-1:0] out_v2_x,
  input logic [COORD_WIDTH-1:0] out_v2_y,
  input logic [COORD_WIDTH-1:0] out_v2_z,
  input logic                   last_of_run
);

  // stalled beat stays up with the same payload
  `TPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TPC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_v0_x) && $stable(out_v1_y) && $stable(out_v2_z) && $stable(last_of_run))

  // the second triangle of a pair follows with no gap
  `TPC_ASSERT_NEXT(a_pair_back_to_back, clk, rst, out_valid && out_ready && !last_of_run, out_valid && last_of_run)

  // the pair shares the edge B, I(A,C)
  `TPC_ASSERT_NEXT(a_pair_shared_edge, clk, rst, out_valid && out_ready && !last_of_run, out_v0_x == $past(out_v1_x) && out_v0_y == $past(out_v1_y) && out_v0_z == $past(out_v1_z) && out_v1_x == $past(out_v2_x) && out_v1_y == $past(out_v2_y) && out_v1_z == $past(out_v2_z))

endmodule

bind triangle_plane_clipper_unit tpc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tpc_checker (.*);
`default_nettype wire

FILE: verif/tpc_clip_checker.sv
`default_nettype none
// Watches both channels of the clipper, predicts the clipped triangles of each
// accepted beat and compares them, in order, with the result beats.
module tpc_clip_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [8:0][31:0] in_coords,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [8:0][31:0] out_coords,
  input  logic        last_of_run,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          tris_seen
);

  typedef logic signed [127:0] wide_t;
  typedef logic [2:0][31:0] vert_t;
  typedef struct packed {
    logic [8:0][31:0] coords;
    logic             last;
  } tri_beat_t;

  vert_t     plane_pt, plane_nrm;
  tri_beat_t clipped_q[$];
  int        mode_cnt[4];

  // Signed distance of a vertex from the plane, exact
  function automatic wide_t plane_dist(vert_t p);
    wide_t s, n, a, b;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      n = wide_t'($signed(plane_nrm[c]));
      a = wide_t'($signed(p[c]));
      b = wide_t'($signed(plane_pt[c]));
      s = s + n * (a - b);
    end
    return s;
  endfunction

  // Point where edge a->b crosses the plane (da >= 0 > db)
  function automatic vert_t edge_cut(vert_t a, vert_t b, wide_t da, wide_t db);
    wide_t den, tq, diff, mg, m, r;
    vert_t res;
    den = da - db;
    tq = (da <<< 32) / den;
    for (int c = 0; c < 3; c++) begin
      diff = wide_t'($signed(b[c])) - wide_t'($signed(a[c]));
      mg = (diff < 0) ? -diff : diff;
      m = (mg * tq + (wide_t'(1) <<< 31)) >>> 32;
      r = (diff < 0) ? wide_t'($signed(a[c])) - m : wide_t'($signed(a[c])) + m;
      res[c] = r[31:0];
    end
    return res;
  endfunction

  function automatic tri_beat_t make_tri(vert_t p0, vert_t p1, vert_t p2, logic last);
    tri_beat_t t;
    for (int c = 0; c < 3; c++) begin
      t.coords[c] = p0[c];
      t.coords[3+c] = p1[c];
      t.coords[6+c] = p2[c];
    end
    t.last = last;
    return t;
  endfunction

  // Predict the clipped triangles for one input beat
  task automatic predict_clip(logic [8:0][31:0] cin);
    vert_t v[3];
    wide_t d[3];
    int ins[3], outs[3];
    int nin, nout;
    vert_t i1, i2;
    nin = 0;
    nout = 0;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) v[k][c] = cin[k*3+c];
      d[k] = plane_dist(v[k]);
      if (d[k] >= 0) begin
        ins[nin] = k;
        nin++;
      end else begin
        outs[nout] = k;
        nout++;
      end
    end
    case (nin)
      0: mode_cnt[tpc_pkg::CLIP_NONE]++;
      3: begin
        mode_cnt[tpc_pkg::CLIP_ALL]++;
        clipped_q.push_back(make_tri(v[0], v[1], v[2], 1'b1));
      end
      1: begin
        mode_cnt[tpc_pkg::CLIP_ONE]++;
        i1 = edge_cut(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
        i2 = edge_cut(v[ins[0]], v[outs[1]], d[ins[0]], d[outs[1]]);
        clipped_q.push_back(make_tri(v[ins[0]], i1, i2, 1'b1));
      end
      default: begin
        mode_cnt[tpc_pkg::CLIP_TWO]++;
        i1 = edge_cut(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
        i2 = edge_cut(v[ins[1]], v[outs[0]], d[ins[1]], d[outs[0]]);
        clipped_q.push_back(make_tri(v[ins[0]], v[ins[1]], i1, 1'b0));
        clipped_q.push_back(make_tri(v[ins[1]], i1, i2, 1'b1));
      end
    endcase
  endtask

  // Compare one result beat with the oldest prediction
  task automatic check_beat();
    tri_beat_t exp_t;
    string names[9];
    names = '{"out_v0_x", "out_v0_y", "out_v0_z", "out_v1_x", "out_v1_y",
              "out_v1_z", "out_v2_x", "out_v2_y", "out_v2_z"};
    if (clipped_q.size() == 0) begin
      $error("unexpected result beat");
      errors++;
    end else begin
      exp_t = clipped_q.pop_front();
      for (int f = 0; f < 9; f++) begin
        if (out_coords[f] !== exp_t.coords[f]) begin
          $error("%s: expected %h, got %h", names[f], exp_t.coords[f], out_coords[f]);
          errors++;
        end
      end
      if (last_of_run !== exp_t.last) begin
        $error("last_of_run: expected %b, got %b", exp_t.last, last_of_run);
        errors++;
      end
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      plane_pt <= '0;
      plane_nrm <= {32'(tpc_pkg::NORMAL_Z_RESET), 32'h0, 32'h0};
      clipped_q.delete();
      errors = 0;
      results_seen = 0;
      tris_seen <= 0;
      for (int i = 0; i < 4; i++) mode_cnt[i] = 0;
    end else begin
      if (cfg_wr_en) begin
        case (tpc_pkg::cfg_reg_t'(cfg_index))
          tpc_pkg::REG_POINT_X:  plane_pt[0] <= cfg_data;
          tpc_pkg::REG_POINT_Y:  plane_pt[1] <= cfg_data;
          tpc_pkg::REG_POINT_Z:  plane_pt[2] <= cfg_data;
          tpc_pkg::REG_NORMAL_X: plane_nrm[0] <= cfg_data;
          tpc_pkg::REG_NORMAL_Y: plane_nrm[1] <= cfg_data;
          tpc_pkg::REG_NORMAL_Z: plane_nrm[2] <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) begin
        predict_clip(in_coords);
        tris_seen <= tris_seen + 1;
      end
    end
    pending = clipped_q.size();
  end

  final begin
    if (clipped_q.size() != 0) $error("%0d result beats never arrived", clipped_q.size());
  end

endmodule
`default_nettype wire

FILE: verif/tb_triangle_plane_clipper_unit.sv
`default_nettype none
module tb_triangle_plane_clipper_unit;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 60;
  localparam int HOLD_LEN = 400;
  localparam int PHASE_ITEMS = 300;

  logic clk, rst;
  logic cfg_wr_en;
  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready, last_of_run;
  logic [8:0][31:0] in_coords, out_coords;
  logic in_fire;
  logic quiet, hold_req, hold_done;
  int errors, pending, results_seen, tris_seen;
  int idle_cycles;

  triangle_plane_clipper_unit #(.COORD_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_v0_x(in_coords[0]), .in_v0_y(in_coords[1]), .in_v0_z(in_coords[2]),
    .in_v1_x(in_coords[3]), .in_v1_y(in_coords[4]), .in_v1_z(in_coords[5]),
    .in_v2_x(in_coords[6]), .in_v2_y(in_coords[7]), .in_v2_z(in_coords[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_v0_x(out_coords[0]), .out_v0_y(out_coords[1]), .out_v0_z(out_coords[2]),
    .out_v1_x(out_coords[3]), .out_v1_y(out_coords[4]), .out_v1_z(out_coords[5]),
    .out_v2_x(out_coords[6]), .out_v2_y(out_coords[7]), .out_v2_z(out_coords[8]),
    .last_of_run(last_of_run)
  );

  tpc_clip_checker chk (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_coords(in_coords),
    .out_valid(out_valid), .out_ready(out_ready), .out_coords(out_coords),
    .last_of_run(last_of_run),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .tris_seen(tris_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Input beat flag, read at the following falling edge
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) <<< 8;
      default: return $urandom_range(0, 3) - 1;
    endcase
  endfunction

  // Offer one triangle; entered and left at a falling edge
  task automatic send_tri(logic [8:0][31:0] coords);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_coords <= coords;
    do @(negedge clk); while (!in_fire);
  endtask

  // Drain, then let any no-result triangle clear the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(tpc_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_plane(logic [2:0][31:0] pt, logic [2:0][31:0] nrm);
    write_reg(tpc_pkg::REG_POINT_X, pt[0]);
    write_reg(tpc_pkg::REG_POINT_Y, pt[1]);
    write_reg(tpc_pkg::REG_POINT_Z, pt[2]);
    write_reg(tpc_pkg::REG_NORMAL_X, nrm[0]);
    write_reg(tpc_pkg::REG_NORMAL_Y, nrm[1]);
    write_reg(tpc_pkg::REG_NORMAL_Z, nrm[2]);
  endtask

  // Triangle with chosen z values and random or extreme x, y
  function automatic logic [8:0][31:0] tri_z(logic [31:0] z0, logic [31:0] z1,
                                             logic [31:0] z2);
    logic [8:0][31:0] t;
    for (int i = 0; i < 9; i++) t[i] = rand_coord();
    t[2] = z0;
    t[5] = z1;
    t[8] = z2;
    return t;
  endfunction

  logic [8:0][31:0] rnd_tri;
  logic [2:0][31:0] pt, nrm;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hffff_0000;
  localparam logic [31:0] ZMAX = 32'h7fff_ffff;
  localparam logic [31:0] ZMIN = 32'h8000_0000;

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_coords <= '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every inside/outside pattern under the reset plane z >= 0
    send_tri(tri_z(ONE, ONE, ONE));
    send_tri(tri_z(MONE, MONE, MONE));
    send_tri(tri_z(ONE, MONE, MONE));
    send_tri(tri_z(MONE, ONE, MONE));
    send_tri(tri_z(MONE, MONE, ONE));
    send_tri(tri_z(ONE, ONE, MONE));
    send_tri(tri_z(ONE, MONE, ONE));
    send_tri(tri_z(MONE, ONE, ONE));
    send_tri(tri_z(0, MONE, MONE));
    send_tri(tri_z(0, 0, 0));
    send_tri(tri_z(0, 32'hffff_ffff, 1));
    send_tri(tri_z(ZMAX, ZMIN, ZMIN));
    send_tri(tri_z(ZMIN, ZMAX, ZMAX));
    send_tri(tri_z(ZMAX, ZMAX, ZMIN));
    send_tri({9{ZMAX}});
    send_tri({9{ZMIN}});
    send_tri({ZMIN, ZMAX, ZMAX, ZMAX, ZMIN, ZMIN, ZMIN, ZMAX, ZMAX});

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      for (int c = 0; c < 3; c++) begin
        case (phase)
          0: begin pt[c] = '0; nrm[c] = (c == 2) ? ONE : '0; end
          1: begin pt[c] = rand_coord(); nrm[c] = $urandom(); end
          2: begin pt[c] = ZMIN; nrm[c] = ZMAX; end
          3: begin pt[c] = ZMAX; nrm[c] = ZMIN; end
          4: begin pt[c] = rand_coord(); nrm[c] = '0; end
          default: begin pt[c] = rand_coord(); nrm[c] = rand_coord(); end
        endcase
      end
      set_plane(pt, nrm);
      if (phase == 1) hold_req = 1'b1;
      if (phase == 5) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        for (int i = 0; i < 9; i++) rnd_tri[i] = rand_coord();
        send_tri(rnd_tri);
      end
    end

    // End of run
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Sent %0d triangles across six plane settings (reset, random, extremes,",
             tris_seen);
    $display("zero normal); checked %0d clipped triangles.", results_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tpc_dist_lane.sv
rtl/tpc_isect_lane.sv
rtl/triangle_plane_clipper_unit.sv
rtl/tpc_checker.sv
verif/tpc_clip_checker.sv
verif/tb_triangle_plane_clipper_unit.sv
